### src/fat12_offset_to_block_defines.svh
// assertion macros of the fat12 offset translator top level
`ifndef FAT12_OFFSET_TO_BLOCK_DEFINES_SVH
`define FAT12_OFFSET_TO_BLOCK_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define F12O2B_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define F12O2B_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/f12o2b_pkg.sv
// shared types and constants of the fat12 offset translator
package f12o2b_pkg;

	localparam int IDX_W = 13;
	localparam int BLK_W = 12;
	localparam int OFS_W = 32;
	localparam int OIB_W = 9;

	localparam logic [BLK_W-1:0] FIRST_LINK = 12'h002;
	localparam logic [BLK_W-1:0] LAST_LINK  = 12'hffd;
	localparam logic [BLK_W-1:0] CHAIN_END  = 12'hfff;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// table accesses needed to follow one link
	typedef struct packed {
		logic             chain_end;
		logic [IDX_W-1:0] addr0;
		logic             ok0;
		logic [IDX_W-1:0] addr1;
		logic             ok1;
	} link_req_t;

endpackage

### src/fat12_offset_to_block.sv
// fat12 offset translator top level: table memory and chain walking sequencer
//
// Usage: drive an item on opcode/byte_index/byte_value/head_block/byte_offset
// and raise start; the item is taken at a clock edge where start is high and
// busy is low. A load (opcode 0) writes one byte of the packed table when it
// is taken and gives no result; indexes past the table are dropped.
// A query (opcode 1) walks the chain one link per whole block in the offset.
// Each link takes two byte reads and one decode step, forced by the single
// read port of the table memory; a link from a block outside the link range
// or past the table ends the chain in the check step instead. The walk goes on
// until the offset is reached or the chain ends, and busy stays high from the
// accepting edge until the done strobe; a new transaction can be taken at the
// edge that ends the done cycle.
// The result sits on block_index/offset_in_block/past_end for the one cycle
// that done is high; the receiver cannot stall, so it must take it then.
// After reset the table is swept to zero, one byte a cycle, over all
// 3*TABLE_ENTRIES/2 bytes (6144 by default); busy is high during the sweep.
`include "fat12_offset_to_block_defines.svh"

module fat12_offset_to_block #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int BLOCK_BYTES   = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         opcode,
	input  logic [f12o2b_pkg::IDX_W-1:0] byte_index,
	input  logic [7:0]                   byte_value,
	input  logic [f12o2b_pkg::BLK_W-1:0] head_block,
	input  logic [f12o2b_pkg::OFS_W-1:0] byte_offset,
	output logic                         done,
	output logic [f12o2b_pkg::BLK_W-1:0] block_index,
	output logic [f12o2b_pkg::OIB_W-1:0] offset_in_block,
	output logic                         past_end
);

	localparam int TABLE_BYTES = (3 * TABLE_ENTRIES) / 2;
	localparam int AW          = $clog2(TABLE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_BYTES - 1);
	localparam logic [f12o2b_pkg::IDX_W-1:0] BYTE_LIMIT = 13'(TABLE_BYTES);
	localparam logic [f12o2b_pkg::OFS_W-1:0] BLOCK_LEN = 32'(BLOCK_BYTES);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_RD1   = 3'd3;
	localparam logic [2:0] ST_LINK  = 3'd4;

	logic [2:0]                   state_q;
	logic [AW-1:0]                clr_cnt_q;
	logic [f12o2b_pkg::BLK_W-1:0] blk_q;
	logic [f12o2b_pkg::OFS_W-1:0] rem_q;
	logic [7:0]                   byte0_q;
	logic [7:0]                   rdata_q;
	logic                         rd_ok_q;
	logic                         done_q;
	logic [f12o2b_pkg::BLK_W-1:0] block_index_q;
	logic [f12o2b_pkg::OIB_W-1:0] offset_q;
	logic                         past_end_q;

	logic [7:0] mem [TABLE_BYTES];

	f12o2b_pkg::link_req_t        req;
	logic [f12o2b_pkg::BLK_W-1:0] next_blk;
	logic [7:0]                   rbyte;
	logic                         accept;
	logic                         we;
	logic [AW-1:0]                waddr;
	logic [7:0]                   wdata;
	logic                         re;
	logic [f12o2b_pkg::IDX_W-1:0] raddr;
	logic                         rok;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign rbyte  = rd_ok_q ? rdata_q : 8'h00;

	f12o2b_link #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_link (
		.blk     (blk_q),
		.byte_a  (byte0_q),
		.byte_b  (rbyte),
		.req     (req),
		.next_blk(next_blk)
	);

	// write port: clearing sweep or a load transaction
	always_comb begin
		we    = 1'b0;
		waddr = clr_cnt_q;
		wdata = 8'h00;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (accept && opcode == f12o2b_pkg::OP_LOAD && byte_index < BYTE_LIMIT) begin
			we    = 1'b1;
			waddr = byte_index[AW-1:0];
			wdata = byte_value;
		end
	end

	// read port: first byte of the entry in check, second in rd1
	always_comb begin
		raddr = (state_q == ST_RD1) ? req.addr1 : req.addr0;
		rok   = (state_q == ST_RD1) ? req.ok1 : req.ok0;
		re    = (state_q == ST_RD1) ||
			(state_q == ST_CHECK && blk_q != f12o2b_pkg::CHAIN_END && rem_q >= BLOCK_LEN);
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_ok_q <= rok;
			if (rok) begin
				rdata_q <= mem[raddr[AW-1:0]];
			end
		end
		if (state_q == ST_RD1) begin
			byte0_q <= rbyte;
		end
	end

	// sequencer: clear sweep, then one query walk at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (accept && opcode == f12o2b_pkg::OP_QUERY) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (blk_q == f12o2b_pkg::CHAIN_END || rem_q < BLOCK_LEN) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (!req.chain_end) begin
						state_q <= ST_RD1;
					end
				end
				ST_RD1: begin
					state_q <= ST_LINK;
				end
				ST_LINK: begin
					state_q <= ST_CHECK;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// walk datapath: remainder count-down, current block and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					blk_q <= head_block;
					rem_q <= byte_offset;
				end
			end
			ST_CHECK: begin
				if (blk_q == f12o2b_pkg::CHAIN_END) begin
					block_index_q <= '0;
					offset_q      <= '0;
					past_end_q    <= 1'b1;
				end else if (rem_q < BLOCK_LEN) begin
					block_index_q <= blk_q;
					offset_q      <= rem_q[f12o2b_pkg::OIB_W-1:0];
					past_end_q    <= 1'b0;
				end else begin
					rem_q <= rem_q - BLOCK_LEN;
					if (req.chain_end) begin
						blk_q <= f12o2b_pkg::CHAIN_END;
					end
				end
			end
			ST_LINK: begin
				blk_q <= next_blk;
			end
			default: begin
				blk_q <= blk_q;
			end
		endcase
	end

	assign done            = done_q;
	assign block_index     = block_index_q;
	assign offset_in_block = offset_q;
	assign past_end        = past_end_q;

	`F12O2B_ASSERT_NOW(a_past_end_zero, clk, arst_n, done && past_end, block_index == '0 && offset_in_block == '0, "past_end result carries nonzero block or offset")
	`F12O2B_ASSERT_NOW(a_live_block, clk, arst_n, done && !past_end, block_index != f12o2b_pkg::CHAIN_END, "live result carries the chain end code")
	`F12O2B_ASSERT_NEXT(a_query_busy, clk, arst_n, accept && opcode == f12o2b_pkg::OP_QUERY, busy && !done, "query transaction did not start a walk")
	`F12O2B_ASSERT_NOW(a_link_order, clk, arst_n, state_q == ST_LINK, $past(state_q) == ST_RD1, "link decode without both table reads")

endmodule

### src/f12o2b_link.sv
// decoder for one fat12 link: byte addresses and unpacking of the entry
module f12o2b_link #(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic [f12o2b_pkg::BLK_W-1:0] blk,
	input  logic [7:0]                   byte_a,
	input  logic [7:0]                   byte_b,
	output f12o2b_pkg::link_req_t        req,
	output logic [f12o2b_pkg::BLK_W-1:0] next_blk
);

	localparam int TABLE_BYTES = (3 * TABLE_ENTRIES) / 2;
	localparam logic [f12o2b_pkg::IDX_W-1:0] ENTRY_LIMIT = 13'(TABLE_ENTRIES);
	localparam logic [f12o2b_pkg::IDX_W-1:0] BYTE_LIMIT  = 13'(TABLE_BYTES);

	logic [f12o2b_pkg::IDX_W-1:0] half;
	logic [f12o2b_pkg::IDX_W-1:0] base;
	logic [f12o2b_pkg::BLK_W-1:0] raw;

	// byte pair of the entry: lo/mid for even blocks, mid/hi for odd ones
	always_comb begin
		half          = {2'b00, blk[f12o2b_pkg::BLK_W-1:1]};
		base          = half + (half << 1);
		req.chain_end = (blk < f12o2b_pkg::FIRST_LINK) || (blk > f12o2b_pkg::LAST_LINK) ||
			({1'b0, blk} >= ENTRY_LIMIT);
		req.addr0     = blk[0] ? base + 13'd1 : base;
		req.addr1     = blk[0] ? base + 13'd2 : base + 13'd1;
		req.ok0       = req.addr0 < BYTE_LIMIT;
		req.ok1       = req.addr1 < BYTE_LIMIT;
	end

	// unpack 12-bit entry, anything outside the link range ends the chain
	always_comb begin
		raw = blk[0] ? {byte_b, byte_a[7:4]} : {byte_b[3:0], byte_a};
		if (raw < f12o2b_pkg::FIRST_LINK || raw > f12o2b_pkg::LAST_LINK) begin
			next_blk = f12o2b_pkg::CHAIN_END;
		end else begin
			next_blk = raw;
		end
	end

endmodule
